>>> rtl/assert_macros.svh
// Assertion helpers shared by the frame fill RTL.
// Both macros sample on clk and are switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge.
`define CRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Checks that a condition is never true.
`define CRF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> rtl/crf_pkg.sv
`default_nettype none

package crf_pkg;

  // Frame geometry.
  localparam int SIDE    = 128;
  localparam int DEPTH   = SIDE * SIDE;
  localparam int IDX_W   = $clog2(SIDE);
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PIX_W   = 8;
  localparam int COORD_W = 11;

  localparam logic signed [COORD_W-1:0] SIDE_S   = COORD_W'(SIDE);
  localparam logic [IDX_W-1:0]          IDX_LAST = IDX_W'(SIDE - 1);
  localparam logic [PIX_W-1:0]          BG_RESET = PIX_W'(128);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_FILL  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new command
    logic step;      // write one pixel and advance the scan position
    logic rd;        // issue a frame read at the held position
    logic out_load;  // move read data into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;     // the clipped fill rectangle holds no pixel
    logic last;      // the scan position is the last pixel of the rectangle
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/crf_ram.sv
`default_nettype none

module crf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/crf_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module crf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_op,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  crf_pkg::sts_t sts,
  output crf_pkg::cmd_t cmd
);

  import crf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_RD_ADDR,
    S_RD_DATA
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;
  op_t    op;

  assign op       = op_t'(in_op);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = accept;
        if (accept) begin
          unique case (op)
            OP_CLEAR: state_nxt = S_SWEEP;
            OP_FILL:  state_nxt = sts.empty ? S_IDLE : S_SWEEP;
            OP_READ:  state_nxt = S_RD_ADDR;
            OP_NONE:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_SWEEP: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD_ADDR: begin
        cmd.rd    = 1'b1;
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        // Hold the read data in the RAM until the output slot frees up.
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `CRF_ASSERT(a_read_starts, accept && (op == OP_READ) |=> state_r == S_RD_ADDR, "read not started")
  `CRF_ASSERT(a_out_source, $rose(out_valid_r) |-> $past(state_r == S_RD_DATA), "stray result")

endmodule

`default_nettype wire

>>> rtl/crf_dp.sv
`default_nettype none

`include "assert_macros.svh"

module crf_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  crf_pkg::cmd_t               cmd,
  output crf_pkg::sts_t               sts,
  input  logic [1:0]                  in_op,
  input  logic [7:0]                  in_colour,
  input  logic signed [8:0]           in_left,
  input  logic signed [8:0]           in_top,
  input  logic [7:0]                  in_span_x,
  input  logic [7:0]                  in_span_y,
  input  logic                        cfg_wr_en,
  input  logic [crf_pkg::PIX_W-1:0]   cfg_wr_data,
  output logic [crf_pkg::PIX_W-1:0]   out_pixel
);

  import crf_pkg::*;

  op_t op;

  // Clipping of the requested rectangle against the frame.
  logic signed [COORD_W-1:0] left_s, top_s, spx_s, spy_s, right_s, bot_s;
  logic signed [COORD_W-1:0] c0_s, c1_s, r0_s, r1_s, c1m_s, r1m_s;
  logic                      in_frame;

  logic [PIX_W-1:0] bg_r;
  logic [PIX_W-1:0] colour_r, colour_nxt;
  logic [IDX_W-1:0] c_r, c_nxt, r_r, r_nxt;
  logic [IDX_W-1:0] c_first_r, c_first_nxt, c_last_r, c_last_nxt;
  logic [IDX_W-1:0] r_last_r, r_last_nxt;
  logic             inrange_r;
  logic [PIX_W-1:0] pixel_r;
  logic [ADDR_W-1:0] addr;
  logic [PIX_W-1:0] rdata;
  logic             col_end;

  assign op = op_t'(in_op);

  assign left_s  = COORD_W'(in_left);
  assign top_s   = COORD_W'(in_top);
  assign spx_s   = signed'(COORD_W'(in_span_x));
  assign spy_s   = signed'(COORD_W'(in_span_y));
  assign right_s = left_s + spx_s;
  assign bot_s   = top_s + spy_s;

  assign c0_s  = left_s[COORD_W-1] ? '0 : left_s;
  assign r0_s  = top_s[COORD_W-1] ? '0 : top_s;
  assign c1_s  = (right_s > SIDE_S) ? SIDE_S : right_s;
  assign r1_s  = (bot_s > SIDE_S) ? SIDE_S : bot_s;
  assign c1m_s = c1_s - COORD_W'(1);
  assign r1m_s = r1_s - COORD_W'(1);

  assign sts.empty = (c1_s <= c0_s) || (r1_s <= r0_s);

  assign in_frame = !left_s[COORD_W-1] && (left_s < SIDE_S) &&
                    !top_s[COORD_W-1] && (top_s < SIDE_S);

  // Raster scan: columns run fastest, rows wrap back to the first column.
  assign col_end  = (c_r == c_last_r);
  assign sts.last = col_end && (r_r == r_last_r);

  always_comb begin
    colour_nxt  = colour_r;
    c_first_nxt = c_first_r;
    c_last_nxt  = c_last_r;
    r_last_nxt  = r_last_r;
    c_nxt       = c_r;
    r_nxt       = r_r;
    if (cmd.load) begin
      unique case (op)
        OP_CLEAR: begin
          colour_nxt  = bg_r;
          c_first_nxt = '0;
          c_last_nxt  = IDX_LAST;
          r_last_nxt  = IDX_LAST;
          c_nxt       = '0;
          r_nxt       = '0;
        end
        OP_READ: begin
          c_nxt = left_s[IDX_W-1:0];
          r_nxt = top_s[IDX_W-1:0];
        end
        OP_FILL, OP_NONE: begin
          colour_nxt  = in_colour;
          c_first_nxt = c0_s[IDX_W-1:0];
          c_last_nxt  = c1m_s[IDX_W-1:0];
          r_last_nxt  = r1m_s[IDX_W-1:0];
          c_nxt       = c0_s[IDX_W-1:0];
          r_nxt       = r0_s[IDX_W-1:0];
        end
      endcase
    end else if (cmd.step) begin
      if (col_end) begin
        c_nxt = c_first_r;
        r_nxt = r_r + IDX_W'(1);
      end else begin
        c_nxt = c_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r <= BG_RESET;
    end else if (cfg_wr_en) begin
      bg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    colour_r  <= colour_nxt;
    c_first_r <= c_first_nxt;
    c_last_r  <= c_last_nxt;
    r_last_r  <= r_last_nxt;
    c_r       <= c_nxt;
    r_r       <= r_nxt;
    if (cmd.load) begin
      inrange_r <= in_frame;
    end
    if (cmd.out_load) begin
      pixel_r <= inrange_r ? rdata : '0;
    end
  end

  assign addr = ADDR_W'(r_r) * ADDR_W'(SIDE) + ADDR_W'(c_r);

  crf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (cmd.step),
    .waddr (addr),
    .wdata (colour_r),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (rdata)
  );

  assign out_pixel = pixel_r;

  `CRF_ASSERT_NEVER(a_col_bound, cmd.step && ((c_r > c_last_r) || (c_r < c_first_r)), "column out of rectangle")
  `CRF_ASSERT(a_row_bound, cmd.step |-> r_r <= r_last_r, "row out of rectangle")

endmodule

`default_nettype wire

>>> rtl/clipped_rectangle_fill_top.sv
`default_nettype none

// Grayscale frame store of 128 by 128 pixels with clear, clipped rectangle
// fill and single pixel read. Commands arrive as beats on the in_ channel;
// only a read produces a beat on the out_ channel. A beat moves on a rising
// edge where valid is high and stall is low.
// A clear writes cfg_wr_data's last value (128 after reset) into all 16384
// pixels, one pixel per cycle, and in_stall stays high until the sweep ends.
// A fill writes only the part of the rectangle that lies inside the frame,
// one pixel per cycle; a fill that clips to nothing writes no pixel and
// the block stays idle.
// A read goes through the RAM read register, then into the output register
// once the output slot is free. Off-frame reads return zero.
// Reading before the first clear returns whatever the RAM holds.
// The frame RAM moves one pixel per cycle and sets the rate: one command
// is worked on at a time and in_stall stays high until it finishes. A fill
// or clear may be accepted while an earlier read result still waits on a
// stalled output; a new read then waits in the block until the output
// register frees up.
// Reset (rst_n, synchronous, active low) returns the controller to idle,
// drops out_valid and sets the background to 128; the frame is not cleared.
// cfg_wr_en may be pulsed only while the block is idle.

module clipped_rectangle_fill_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_colour,
  input  logic signed [8:0] in_left,
  input  logic signed [8:0] in_top,
  input  logic [7:0]        in_span_x,
  input  logic [7:0]        in_span_y,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_pixel
);

  import crf_pkg::*;

  // The controller sequences each command; the datapath owns the frame RAM,
  // the scan counters and the output pixel register.
  cmd_t cmd;
  sts_t sts;

  crf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  crf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_op),
    .in_colour   (in_colour),
    .in_left     (in_left),
    .in_top      (in_top),
    .in_span_x   (in_span_x),
    .in_span_y   (in_span_y),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_pixel   (out_pixel)
  );

endmodule

`default_nettype wire
